// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is held
`define AST_IMPLY(name, ck, rstn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// next-cycle implication, ignored while reset is held
`define AST_NEXT(name, ck, rstn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/core/dst_pkg.sv
`timescale 1ns / 1ps

package dst_pkg;

  localparam int MAX_DELIM  = 8;
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = $clog2(MAX_DELIM + 1);
  localparam int LEN_W      = 4;
  localparam int DELIM_W    = MAX_DELIM * BYTE_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = DELIM_W;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [LEN_W-1:0]     len_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t CFG_IDX_LEN   = 1'b0;
  localparam cfg_idx_t CFG_IDX_BYTES = 1'b1;

  // input kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam len_t                 DELIM_LEN_RST   = 4'd1;
  localparam logic [DELIM_W-1:0]   DELIM_BYTES_RST = 64'd32;
  localparam byte_t                NUL_BYTE        = 8'h00;

  typedef struct packed {
    byte_t data;
    logic  is_byte;
    logic  starts_token;
    logic  last_of_run;
  } out_word_t;

  localparam out_word_t MARKER_WORD = '{
    data:         NUL_BYTE,
    is_byte:      1'b0,
    starts_token: 1'b0,
    last_of_run:  1'b1
  };

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic eq_cur;
    logic eq_prev;
  } cell_cmp_t;

  typedef struct packed {
    logic busy;
    cnt_t cnt;
  } ctl_stat_t;

  // effective delimiter length, clamped to 1..MAX_DELIM
  function automatic cnt_t eff_len(len_t len);
    if (len == '0) begin
      return CNT_W'(1);
    end
    if (CNT_W'(len) > CNT_W'(MAX_DELIM)) begin
      return CNT_W'(MAX_DELIM);
    end
    return CNT_W'(len);
  endfunction

endpackage

// File: rtl/core/dst_cell.sv
`timescale 1ns / 1ps

module dst_cell import dst_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  byte_t     load_byte,
  input  byte_t     from_next,
  input  byte_t     delim_cur,
  input  byte_t     delim_prev,
  output byte_t     val,
  output cell_cmp_t cmp
);

  byte_t data_r;
  byte_t data_nxt;

  // value seen this cycle, including a byte appended here
  assign val = ctl.load ? load_byte : data_r;

  always_comb begin
    data_nxt    = ctl.shift ? from_next : val;
    cmp.eq_cur  = (val == delim_cur);
    cmp.eq_prev = (val == delim_prev);
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// File: rtl/core/dst_ctrl.sv
`timescale 1ns / 1ps

module dst_ctrl import dst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  input  logic      skid_full,
  input  cnt_t      n,
  input  byte_t     head,
  input  cell_cmp_t cmp [MAX_DELIM],
  output logic      in_stall,
  output cell_ctl_t ctl [MAX_DELIM],
  output logic      push,
  output out_word_t word,
  output ctl_stat_t stat
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_DRAIN,
    M_FLUSH
  } mode_t;

  mode_t mode_r, mode_nxt;
  cnt_t  cnt_r, cnt_nxt;
  logic  tok_r, tok_nxt;

  logic  accept;
  logic  load;
  logic  shift;
  logic  match_cur;
  logic  match_shift;
  logic  do_drain;
  cnt_t  cnt_inc;
  cnt_t  dcnt;
  cnt_t  dleft;

  assign in_stall = (mode_r != M_IDLE) || skid_full;
  assign accept   = in_valid && !in_stall;
  assign cnt_inc  = cnt_r + CNT_W'(1);

  // window against delimiter, as is and one byte further on
  always_comb begin
    match_cur   = 1'b1;
    match_shift = 1'b1;
    for (int i = 0; i < MAX_DELIM; i++) begin
      if (CNT_W'(i) < n && !cmp[i].eq_cur) begin
        match_cur = 1'b0;
      end
    end
    for (int i = 1; i < MAX_DELIM; i++) begin
      if (CNT_W'(i) <= n && !cmp[i].eq_prev) begin
        match_shift = 1'b0;
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    tok_nxt  = tok_r;
    push     = 1'b0;
    shift    = 1'b0;
    load     = 1'b0;
    do_drain = 1'b0;
    dcnt     = cnt_r;
    word     = '{data: head, is_byte: 1'b1, starts_token: !tok_r, last_of_run: 1'b1};

    unique case (mode_r)
      M_IDLE: begin
        if (accept) begin
          if (in_kind == KIND_BYTE) begin
            load = 1'b1;
            if (cnt_inc < n) begin
              cnt_nxt = cnt_inc;
            end else if (cnt_inc == n) begin
              if (match_cur) begin
                cnt_nxt = '0;
                tok_nxt = 1'b0;
              end else begin
                push    = 1'b1;
                shift   = 1'b1;
                tok_nxt = 1'b1;
              end
            end else begin
              do_drain = 1'b1;
              dcnt     = cnt_inc;
            end
          end else begin
            push = 1'b1;
            if (cnt_r == '0) begin
              word    = MARKER_WORD;
              tok_nxt = 1'b0;
            end else begin
              shift            = 1'b1;
              tok_nxt          = 1'b1;
              word.last_of_run = 1'b0;
              cnt_nxt          = cnt_r - CNT_W'(1);
              mode_nxt         = M_FLUSH;
            end
          end
        end
      end
      M_DRAIN: begin
        if (!skid_full) begin
          do_drain = 1'b1;
        end
      end
      M_FLUSH: begin
        if (!skid_full) begin
          push = 1'b1;
          if (cnt_r != '0) begin
            shift            = 1'b1;
            tok_nxt          = 1'b1;
            word.last_of_run = 1'b0;
            cnt_nxt          = cnt_r - CNT_W'(1);
          end else begin
            word     = MARKER_WORD;
            tok_nxt  = 1'b0;
            mode_nxt = M_IDLE;
          end
        end
      end
      default: begin
        mode_nxt = M_IDLE;
      end
    endcase

    dleft = dcnt - CNT_W'(1);
    if (do_drain) begin
      push    = 1'b1;
      shift   = 1'b1;
      tok_nxt = 1'b1;
      if (dleft > n) begin
        word.last_of_run = 1'b0;
        cnt_nxt          = dleft;
        mode_nxt         = M_DRAIN;
      end else if (dleft == n) begin
        if (match_shift) begin
          cnt_nxt  = '0;
          tok_nxt  = 1'b0;
          mode_nxt = M_IDLE;
        end else begin
          word.last_of_run = 1'b0;
          cnt_nxt          = dleft;
          mode_nxt         = M_DRAIN;
        end
      end else begin
        cnt_nxt  = dleft;
        mode_nxt = M_IDLE;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_DELIM; i++) begin
      ctl[i].load  = load && (cnt_r == CNT_W'(i));
      ctl[i].shift = shift;
    end
    stat.busy = (mode_r != M_IDLE);
    stat.cnt  = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      cnt_r  <= '0;
      tok_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      tok_r  <= tok_nxt;
    end
  end

endmodule

// File: rtl/core/dst_skid.sv
`timescale 1ns / 1ps

module dst_skid import dst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  out_word_t push_word,
  output logic      full,
  output logic      out_valid,
  output out_word_t out_word,
  input  logic      out_stall
);

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  out_word_t skid_word_r, skid_word_nxt;

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (out_valid_r && out_stall) begin
      // output held, park the new word
      if (push) begin
        skid_valid_nxt = 1'b1;
        skid_word_nxt  = push_word;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_word_nxt   = skid_word_r;
      skid_valid_nxt = push;
      skid_word_nxt  = push_word;
    end else begin
      out_valid_nxt = push;
      out_word_nxt  = push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

endmodule

// File: rtl/core/delimiter_string_tokenizer.sv
// delimiter string tokenizer
// input channel: in_valid / in_stall carry one word, in_kind says byte or end of
//   string, in_byte the byte; a word is taken when valid is high and stall low
// result channel: out_valid / out_stall carry token bytes with a start-of-token
//   flag, or the end marker; out_last_of_run closes the results of one input word
// config: cfg_we with cfg_index 0 sets the delimiter length (1..8, clamped),
//   index 1 the delimiter bytes, byte i in bits 8i+7..8i; write only when idle
// latency: a result appears on the output one cycle after the word that causes it
// throughput: one result word per cycle; an input word takes max(1, k) cycles,
//   k being its result count (one or none in steady state, so bytes go back to
//   back); bursts come from the end-of-string flush and from a shortened delimiter
// the limit is the single output port of the cell chain: one byte leaves per cycle
// reset: window empty, no token open, delimiter a single space
// a stalled output keeps its word; one more word parks in the skid stage,
//   after which in_stall rises until the output drains
`timescale 1ns / 1ps
`include "assert_macros.svh"

module delimiter_string_tokenizer import dst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  byte_t                 in_byte,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output byte_t                 out_byte,
  output logic                  out_is_byte,
  output logic                  out_starts_token,
  output logic                  out_last_of_run,
  // configuration writes
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  len_t               delim_len_r, delim_len_nxt;
  logic [DELIM_W-1:0] delim_bytes_r, delim_bytes_nxt;
  cnt_t               n;

  // cell chain wiring
  byte_t     cell_val [MAX_DELIM];
  byte_t     cell_nbr [MAX_DELIM];
  byte_t     cell_dprev [MAX_DELIM];
  cell_cmp_t cell_cmp [MAX_DELIM];
  cell_ctl_t cell_ctl [MAX_DELIM];

  logic      push;
  out_word_t push_word;
  out_word_t out_word;
  logic      skid_full;
  ctl_stat_t stat;
  logic      marker_ok;

  always_comb begin
    delim_len_nxt   = delim_len_r;
    delim_bytes_nxt = delim_bytes_r;
    if (cfg_we) begin
      if (cfg_index == CFG_IDX_LEN) begin
        delim_len_nxt = cfg_data[LEN_W-1:0];
      end else begin
        delim_bytes_nxt = cfg_data[DELIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_len_r   <= DELIM_LEN_RST;
      delim_bytes_r <= DELIM_BYTES_RST;
    end else begin
      delim_len_r   <= delim_len_nxt;
      delim_bytes_r <= delim_bytes_nxt;
    end
  end

  assign n = eff_len(delim_len_r);

  // window cells, oldest byte in cell 0; a shift moves every byte one cell down
  for (genvar i = 0; i < MAX_DELIM; i++) begin : g_cell
    if (i == MAX_DELIM - 1) begin : g_tail
      assign cell_nbr[i] = NUL_BYTE;
    end else begin : g_body
      assign cell_nbr[i] = cell_val[i+1];
    end
    // cell 0 has no predecessor, its shifted compare goes unused
    if (i == 0) begin : g_first
      assign cell_dprev[i] = delim_bytes_r[BYTE_W-1:0];
    end else begin : g_rest
      assign cell_dprev[i] = delim_bytes_r[(i-1)*BYTE_W +: BYTE_W];
    end

    dst_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .load_byte  (in_byte),
      .from_next  (cell_nbr[i]),
      .delim_cur  (delim_bytes_r[i*BYTE_W +: BYTE_W]),
      .delim_prev (cell_dprev[i]),
      .val        (cell_val[i]),
      .cmp        (cell_cmp[i])
    );
  end

  // sequencer: append, match, drain after a shortened delimiter, end-of-string flush
  dst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .skid_full (skid_full),
    .n         (n),
    .head      (cell_val[0]),
    .cmp       (cell_cmp),
    .in_stall  (in_stall),
    .ctl       (cell_ctl),
    .push      (push),
    .word      (push_word),
    .stat      (stat)
  );

  // output register plus one skid entry
  dst_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .full      (skid_full),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

  assign out_byte         = out_word.data;
  assign out_is_byte      = out_word.is_byte;
  assign out_starts_token = out_word.starts_token;
  assign out_last_of_run  = out_word.last_of_run;

  // shape of a well-formed end marker
  assign marker_ok = out_last_of_run && !out_starts_token && out_byte == NUL_BYTE;

  // end marker always closes a run and carries no byte
  `AST_IMPLY(a_marker_form, clk, rst_n, out_valid && !out_is_byte, marker_ok)
  // the skid entry is only used behind a held output word
  `AST_IMPLY(a_skid_behind_out, clk, rst_n, skid_full, out_valid)
  // between input words the window is never full
  `AST_IMPLY(a_idle_room, clk, rst_n, !stat.busy, stat.cnt < CNT_W'(MAX_DELIM))
  // a word that does not close its run keeps the input stalled
  `AST_NEXT(a_run_holds_input, clk, rst_n, push && !push_word.last_of_run, in_stall)

endmodule
